/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising edge, switched off while reset is low.
`define MLFD_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// Same-cycle implication built on the form above.
`define MLFD_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
  `MLFD_ASSERT(lbl, clk_i, rstn_i, (ante) |-> (cons), msg)

// Next-cycle implication built on the form above.
`define MLFD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  `MLFD_ASSERT(lbl, clk_i, rstn_i, (ante) |=> (cons), msg)

`endif

/* hw/rtl/mlfd_pkg.sv */
// ----------------------------------------------------------------------------
// mlfd_pkg
// Types and constants shared by the marker/length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam logic [7:0] START_BYTE   = 8'h3f;
  localparam int         HDR_BYTES    = 8;
  localparam logic [2:0] HDR_LAST_IDX = 3'd7;

  typedef enum logic [2:0] {
    ST_PAYLOAD   = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_CHECK     = 3'd3,
    ST_SHORT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic [15:0] frame_type;
    logic [15:0] frame_length;
    logic        last_of_frame;
  } result_t;

  // Handshake between the parser and the output register.
  typedef struct packed {
    logic load;
    logic free;
  } res_ctl_t;

endpackage

/* hw/rtl/marker_length_frame_deframer.sv */
// ----------------------------------------------------------------------------
// marker_length_frame_deframer
// Byte-serial deframer for frames of start byte, length, type, check word
// and payload.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_data_byte        | stream in
//   out     | out_valid, out_stall, out_status,       | results out
//           | out_payload_byte, out_frame_type,       |
//           | out_frame_length, out_last_of_frame     |
//
// One byte per cycle is taken while in_stall is low; each byte waits in an
// input register, and the parser then writes its result into the result
// register, which drives the out ports. A byte that gives no result never
// waits on the output side.
// A stalled result holds the result register; in_stall then rises only while
// the byte held in the input register would give a result.
// Reset (rst_n low, synchronous) puts the parser into hunting and empties
// both registers.
// ----------------------------------------------------------------------------
module marker_length_frame_deframer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output mlfd_pkg::status_t out_status,
  output logic [7:0]        out_payload_byte,
  output logic [15:0]       out_frame_type,
  output logic [15:0]       out_frame_length,
  output logic              out_last_of_frame
);
  import mlfd_pkg::*;

  logic       byte_v_r, byte_v_nxt;
  logic [7:0] byte_r;
  logic       take;
  logic       res_load;
  logic       accept;
  res_ctl_t   ctl;
  result_t    res_p;
  result_t    res_q;

  assign in_stall = byte_v_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    byte_v_nxt = byte_v_r;
    if (accept)    byte_v_nxt = 1'b1;
    else if (take) byte_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else begin
      byte_v_r <= byte_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
    end
  end

  mlfd_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_v_r),
    .byte_data (byte_r),
    .byte_take (take),
    .res_free  (ctl.free),
    .res_load  (res_load),
    .res       (res_p)
  );

  mlfd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_in   (res_p),
    .res_load (res_load),
    .ctl      (ctl),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_out  (res_q)
  );

  assign out_status        = res_q.status;
  assign out_payload_byte  = res_q.payload_byte;
  assign out_frame_type    = res_q.frame_type;
  assign out_frame_length  = res_q.frame_length;
  assign out_last_of_frame = res_q.last_of_frame;

endmodule

/* hw/rtl/mlfd_parse.sv */
// ----------------------------------------------------------------------------
// mlfd_parse
// Frame parser: one buffered byte per cycle unless its result waits for the
// result register; keeps the frame state and forms at most one result per byte.
// ----------------------------------------------------------------------------
module mlfd_parse #(
  parameter int LENGTH_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  input  logic [7:0]       byte_data,
  output logic             byte_take,
  input  logic             res_free,
  output logic             res_load,
  output mlfd_pkg::result_t res
);
  import mlfd_pkg::*;

  // Bits of the received length that are kept.
  localparam int KW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  phase_t                 phase_r,   phase_nxt;
  logic [2:0]             idx_r,     idx_nxt;
  logic [15:0]            length_r,  length_nxt;
  logic [15:0]            type_r,    type_nxt;
  logic                   check_r,   check_nxt;
  logic [LENGTH_BITS-1:0] left_r,    left_nxt;

  logic          has_res;
  logic          chk_now;
  logic [KW-1:0] len_kept;
  logic [15:0]   len_out;

  assign len_kept = length_r[KW-1:0];
  assign len_out  = 16'(len_kept);
  assign chk_now  = check_r | (idx_r[2] && (byte_data != 8'h00));

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    length_nxt = length_r;
    type_nxt   = type_r;
    check_nxt  = check_r;
    left_nxt   = left_r;
    has_res    = 1'b0;
    res        = '{status: ST_BAD_START, payload_byte: 8'h00, frame_type: 16'h0000,
                   frame_length: 16'h0000, last_of_frame: 1'b0};
    unique case (phase_r)
      PH_HEADER: begin
        if (idx_r[2]) begin
          check_nxt = chk_now;
        end else if (idx_r[1]) begin
          if (idx_r[0]) type_nxt[15:8] = byte_data;
          else          type_nxt[7:0]  = byte_data;
        end else begin
          if (idx_r[0]) length_nxt[15:8] = byte_data;
          else          length_nxt[7:0]  = byte_data;
        end
        if (idx_r != HDR_LAST_IDX) begin
          idx_nxt = idx_r + 3'd1;
        end else begin
          // Last check word byte: the header is complete.
          idx_nxt              = 3'd0;
          phase_nxt            = PH_HUNT;
          res.frame_type       = type_r;
          res.frame_length     = len_out;
          if (chk_now) begin
            has_res    = 1'b1;
            res.status = ST_CHECK;
          end else if (len_kept < KW'(HDR_BYTES)) begin
            has_res    = 1'b1;
            res.status = ST_SHORT;
          end else if (len_kept == KW'(HDR_BYTES)) begin
            has_res           = 1'b1;
            res.status        = ST_EMPTY;
            res.last_of_frame = 1'b1;
          end else begin
            left_nxt  = LENGTH_BITS'(len_kept - KW'(HDR_BYTES));
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_res           = 1'b1;
        res.status        = ST_PAYLOAD;
        res.payload_byte  = byte_data;
        res.frame_type    = type_r;
        res.frame_length  = len_out;
        res.last_of_frame = (left_r <= LENGTH_BITS'(1));
        if (res.last_of_frame) begin
          left_nxt  = '0;
          phase_nxt = PH_HUNT;
        end else begin
          left_nxt = left_r - LENGTH_BITS'(1);
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (byte_data == START_BYTE) begin
          phase_nxt  = PH_HEADER;
          idx_nxt    = 3'd0;
          length_nxt = 16'h0000;
          type_nxt   = 16'h0000;
          check_nxt  = 1'b0;
          left_nxt   = '0;
        end else begin
          has_res = 1'b1;
        end
      end
    endcase
  end

  // A byte that yields no result never waits on the output side.
  assign byte_take = byte_valid && (!has_res || res_free);
  assign res_load  = byte_take && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      idx_r    <= 3'd0;
      length_r <= 16'h0000;
      type_r   <= 16'h0000;
      check_r  <= 1'b0;
      left_r   <= '0;
    end else if (byte_take) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      length_r <= length_nxt;
      type_r   <= type_nxt;
      check_r  <= check_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

/* hw/rtl/mlfd_out_reg.sv */
// ----------------------------------------------------------------------------
// mlfd_out_reg
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module mlfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  mlfd_pkg::result_t res_in,
  input  logic              res_load,
  output mlfd_pkg::res_ctl_t ctl,
  output logic              out_valid,
  input  logic              out_stall,
  output mlfd_pkg::result_t res_out
);
  import mlfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Free when empty or when the held item leaves this cycle.
  assign ctl.free = !valid_r || !out_stall;
  assign ctl.load = res_load;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load)        valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.free) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

/* hw/rtl/mlfd_checker.sv */
// ----------------------------------------------------------------------------
// mlfd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        in_data_byte,
  input logic              out_valid,
  input logic              out_stall,
  input mlfd_pkg::status_t out_status,
  input logic [7:0]        out_payload_byte,
  input logic [15:0]       out_frame_type,
  input logic [15:0]       out_frame_length,
  input logic              out_last_of_frame
);
  import mlfd_pkg::*;

  logic [43:0] out_bus;
  assign out_bus = {out_payload_byte, out_frame_type, out_frame_length,
                    out_last_of_frame, out_status};

  `MLFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `MLFD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_bus), "stalled result changed")
  `MLFD_ASSERT_IMP(a_last_kind, clk, rst_n, out_valid && out_last_of_frame, (out_status == ST_PAYLOAD) || (out_status == ST_EMPTY), "end of frame on an error result")
  `MLFD_ASSERT_IMP(a_bad_start, clk, rst_n, out_valid && (out_status == ST_BAD_START), (out_frame_type == 16'h0000) && (out_frame_length == 16'h0000) && (out_payload_byte == 8'h00) && !out_last_of_frame, "bad start result carries frame data")
  `MLFD_ASSERT_IMP(a_empty_len, clk, rst_n, out_valid && (out_status == ST_EMPTY), (out_frame_length == 16'(HDR_BYTES)) && out_last_of_frame, "empty frame with wrong length")

  // Input side fields are visible here for waveform context only.
  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_data_byte);

endmodule

bind marker_length_frame_deframer mlfd_checker u_mlfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_data_byte     (in_data_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_payload_byte (out_payload_byte),
  .out_frame_type   (out_frame_type),
  .out_frame_length (out_frame_length),
  .out_last_of_frame(out_last_of_frame)
);

/* verif/marker_length_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// marker_length_frame_deframer_tb
// Self-checking bench for the deframer. A byte stream of well-formed frames,
// bad headers and line noise is pushed in bursts, the result side stalls in
// changing patterns, and every result is checked against a behavioural
// parser kept in a small scoreboard.
// ----------------------------------------------------------------------------
module marker_length_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfd_pkg::*;

  localparam int STREAM_BYTES = 1650;

  typedef enum int {
    FR_PAYLOAD,
    FR_LONG,
    FR_EMPTY,
    FR_SHORT,
    FR_CHECK,
    FR_NOISE
  } frame_kind_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // Scoreboard: a byte-level model of the parser plus the queue of results
  // that it predicts.
  class deframe_board;
    phase_t      phase;
    logic [2:0]  hdr_idx;
    logic [15:0] len_reg;
    logic [15:0] type_reg;
    logic        chk_nz;
    logic [15:0] left;
    result_t     pending[$];
    int          fails;
    int          bytes_in;
    int          seen[5];

    function new();
      phase    = PH_HUNT;
      hdr_idx  = '0;
      len_reg  = '0;
      type_reg = '0;
      chk_nz   = 1'b0;
      left     = '0;
      fails    = 0;
      bytes_in = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      bit      gives;
      r = '0;
      gives = 1'b0;
      bytes_in++;
      case (phase)
        PH_HEADER: begin
          case (hdr_idx)
            3'd0: len_reg[7:0] = b;
            3'd1: len_reg[15:8] = b;
            3'd2: type_reg[7:0] = b;
            3'd3: type_reg[15:8] = b;
            default: if (b != 8'h00) chk_nz = 1'b1;
          endcase
          if (hdr_idx != HDR_LAST_IDX) begin
            hdr_idx++;
          end else begin
            hdr_idx = '0;
            phase = PH_HUNT;
            r.frame_type = type_reg;
            r.frame_length = len_reg;
            // The check word error takes priority over a bad length.
            if (chk_nz) begin
              r.status = ST_CHECK;
              gives = 1'b1;
            end else if (len_reg < HDR_BYTES) begin
              r.status = ST_SHORT;
              gives = 1'b1;
            end else if (len_reg == HDR_BYTES) begin
              r.status = ST_EMPTY;
              r.last_of_frame = 1'b1;
              gives = 1'b1;
            end else begin
              left = 16'(len_reg - HDR_BYTES);
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          r.status = ST_PAYLOAD;
          r.payload_byte = b;
          r.frame_type = type_reg;
          r.frame_length = len_reg;
          r.last_of_frame = (left <= 16'd1);
          gives = 1'b1;
          if (r.last_of_frame) begin
            left = '0;
            phase = PH_HUNT;
          end else begin
            left--;
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == START_BYTE) begin
            phase = PH_HEADER;
            hdr_idx = '0;
            len_reg = '0;
            type_reg = '0;
            chk_nz = 1'b0;
            left = '0;
          end else begin
            r.status = ST_BAD_START;
            gives = 1'b1;
          end
        end
      endcase
      if (gives) pending.push_back(r);
    endfunction

    function void check_result(status_t st, logic [7:0] pb, logic [15:0] ty,
                               logic [15:0] ln, logic last);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with no item waiting: status %0d", st);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (st <= ST_SHORT) seen[st]++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        fails++;
      end
      if (pb !== e.payload_byte) begin
        $error("payload_byte: expected 0x%02h, got 0x%02h", e.payload_byte, pb);
        fails++;
      end
      if (ty !== e.frame_type) begin
        $error("frame_type: expected 0x%04h, got 0x%04h", e.frame_type, ty);
        fails++;
      end
      if (ln !== e.frame_length) begin
        $error("frame_length: expected 0x%04h, got 0x%04h", e.frame_length, ln);
        fails++;
      end
      if (last !== e.last_of_frame) begin
        $error("last_of_frame: expected %0b, got %0b", e.last_of_frame, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     out_status;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_frame_type;
  logic [15:0] out_frame_length;
  logic        out_last_of_frame;

  deframe_board board;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int          rx_hold = 0;

  marker_length_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_payload_byte  (out_payload_byte),
    .out_frame_type    (out_frame_type),
    .out_frame_length  (out_frame_length),
    .out_last_of_frame (out_last_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver switches between stall patterns, each held for a random span.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(50, 400);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_stall <= (rx_hold % 5) < 2;
      default:     out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_status, out_payload_byte, out_frame_type,
                         out_frame_length, out_last_of_frame);
  end

  // Must be called at a rising edge. Gaps are inserted between bursts; within
  // a burst valid stays high from one item to the next.
  task automatic push_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b);
    burst_left--;
  endtask

  task automatic send_header(input logic [15:0] len, input logic [15:0] typ,
                             input logic [31:0] chk);
    push_byte(START_BYTE);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    push_byte(typ[7:0]);
    push_byte(typ[15:8]);
    for (int i = 0; i < 4; i++) push_byte(chk[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [31:0] chk);
    send_header(len, 16'($urandom), chk);
    if (chk == 32'd0 && len > HDR_BYTES)
      for (int i = 0; i < len - HDR_BYTES; i++) push_byte(8'($urandom));
  endtask

  function automatic logic [31:0] bad_check();
    logic [31:0] c;
    c = '0;
    c[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(1, 255));
    return c;
  endfunction

  initial begin
    frame_kind_t kind;
    logic [7:0]  junk;
    int          pick;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad start bytes, then each header outcome and payloads of one
    // and two bytes at the byte extremes and the start byte value.
    push_byte(8'h00);
    push_byte(8'hff);
    send_header(16'd8, 16'hffff, 32'd0);
    send_header(16'd0, 16'h0000, 32'd0);
    send_header(16'hffff, 16'h0000, 32'h8000_0000);
    send_header(16'd9, 16'h5a5a, 32'd0);
    push_byte(8'hff);
    send_header(16'd10, 16'ha5a5, 32'd0);
    push_byte(8'h00);
    push_byte(8'h3f);

    while (board.bytes_in < STREAM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      kind = FR_PAYLOAD;
      else if (pick < 50) kind = FR_LONG;
      else if (pick < 62) kind = FR_EMPTY;
      else if (pick < 72) kind = FR_SHORT;
      else if (pick < 84) kind = FR_CHECK;
      else                kind = FR_NOISE;
      case (kind)
        FR_PAYLOAD: send_frame(16'($urandom_range(9, 40)), 32'd0);
        FR_LONG:    send_frame(16'($urandom_range(41, 300)), 32'd0);
        FR_EMPTY:   send_frame(16'd8, 32'd0);
        FR_SHORT:   send_frame(16'($urandom_range(0, 7)), 32'd0);
        FR_CHECK: begin
          pick = $urandom_range(0, 3);
          if (pick == 0)      send_frame(16'hffff, bad_check());
          else if (pick == 1) send_frame(16'($urandom_range(0, 8)), bad_check());
          else                send_frame(16'($urandom), bad_check());
        end
        default: begin
          // Line noise never holds a marker, so it cannot open a runaway frame.
          repeat ($urandom_range(1, 4)) begin
            junk = 8'($urandom);
            if (junk == START_BYTE) junk = ~junk;
            push_byte(junk);
          end
        end
      endcase
    end

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes; results: %0d payload, %0d empty, %0d bad start,",
             board.bytes_in, board.seen[ST_PAYLOAD], board.seen[ST_EMPTY],
             board.seen[ST_BAD_START]);
    $display("  %0d check word errors, %0d short lengths; %0d mismatches.",
             board.seen[ST_CHECK], board.seen[ST_SHORT], board.fails);
    if (board.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
